[sv/lifetime_first_fit_offset_planner_top_defines.svh]
`ifndef LIFETIME_FIRST_FIT_OFFSET_PLANNER_TOP_DEFINES_SVH
`define LIFETIME_FIRST_FIT_OFFSET_PLANNER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LFFOP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LFFOP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/lffop_pkg.sv]
`timescale 1ns / 1ps

package lffop_pkg;

    // default depth of the active range table
    localparam int MAX_ACTIVE_DEF = 16;

    // field widths
    localparam int POS_W   = 20;
    localparam int SIZE_W  = 24;
    localparam int OFF_W   = 27;
    localparam int ALIGN_W = 13;
    localparam int CAP_W   = 26;

    // candidate offset before clamping: offset + size + alignment pad
    localparam int CAND_W  = OFF_W + 1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CAP_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALIGNMENT = 2'd0,
        REG_CAPACITY  = 2'd1
    } cfg_reg_t;

    // register reset values
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 13'd64;
    localparam logic [CAP_W-1:0]   CAP_RESET   = 26'd1048576;

    // largest representable offset and peak
    localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

endpackage

[sv/lffop_channels.sv]
`timescale 1ns / 1ps

// lifetime word channel
interface lffop_item_if;
    import lffop_pkg::*;

    logic              valid;
    logic              ready;
    logic              new_set;
    logic [POS_W-1:0]  lifetime_start;
    logic [POS_W-1:0]  lifetime_end;
    logic [SIZE_W-1:0] block_size;

    modport source (output valid, new_set, lifetime_start, lifetime_end, block_size,
                    input ready);
    modport sink   (input valid, new_set, lifetime_start, lifetime_end, block_size,
                    output ready);
endinterface

// placement result word channel
interface lffop_result_if;
    import lffop_pkg::*;

    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] placed_offset;
    logic [OFF_W-1:0] peak_bytes;
    logic             over_capacity;
    logic             table_full;

    modport source (output valid, placed_offset, peak_bytes, over_capacity, table_full,
                    input ready);
    modport sink   (input valid, placed_offset, peak_bytes, over_capacity, table_full,
                    output ready);
endinterface

// register write channel
interface lffop_cfg_if;
    import lffop_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/lifetime_first_fit_offset_planner_top.sv]
`timescale 1ns / 1ps
// channel   dir   handshake      payload
// item      in    valid/ready    new_set, lifetime_start, lifetime_end, block_size
// result    out   valid/ready    placed_offset, peak_bytes, over_capacity, table_full
// cfg       in    valid/ready    index, data (0 alignment, 1 capacity)
//
// one item at a time; an item takes a retire pass over the table, then one more pass
// for each range visited, plus a run of the remainder unit for each visit that
// raises the candidate; the table scan is serial and the remainder unit bit-serial
// reset clears valid bits and peak and loads the register reset values at once; no clearing pass
// a finished word sits in the output register; the next item is accepted meanwhile
// and waits in its final cycle only if the previous word is still not taken

`include "lifetime_first_fit_offset_planner_top_defines.svh"

module lifetime_first_fit_offset_planner_top #(
    parameter int MAX_ACTIVE = lffop_pkg::MAX_ACTIVE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    lffop_item_if.sink     item,
    lffop_result_if.source result,
    lffop_cfg_if.sink      cfg
);
    import lffop_pkg::*;

    localparam int IDX_W     = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
    localparam int CNT_W     = $clog2(MAX_ACTIVE + 1);
    localparam int DIV_CNT_W = $clog2(CAND_W);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_STEP = 6'b000100,
        S_DIV  = 6'b001000,
        S_ADJ  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // item being placed
    logic [POS_W-1:0]  start_reg, start_next;
    logic [POS_W-1:0]  end_reg, end_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    // range table: valid bits in flops, fields in memories
    logic [MAX_ACTIVE-1:0] valid_reg, valid_next;
    logic [POS_W-1:0]      mem_end  [MAX_ACTIVE];
    logic [OFF_W-1:0]      mem_off  [MAX_ACTIVE];
    logic [SIZE_W-1:0]     mem_size [MAX_ACTIVE];
    logic [POS_W-1:0]      rd_end_reg;
    logic [OFF_W-1:0]      rd_off_reg;
    logic [SIZE_W-1:0]     rd_size_reg;
    logic                  mem_we;

    // scan sequencer
    logic [CNT_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] rd_addr;
    logic             first_pass_reg, first_pass_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    // running minimum of the current pass and the key last visited
    logic             best_found_reg, best_found_next;
    logic [OFF_W-1:0] best_off_reg, best_off_next;
    logic [SIZE_W-1:0] best_size_reg, best_size_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [OFF_W-1:0] last_off_reg, last_off_next;
    logic [IDX_W-1:0] last_idx_reg, last_idx_next;

    // candidate offset, kept aligned
    logic [CAND_W-1:0] cand_reg, cand_next;

    // bit-serial remainder unit
    logic [CAND_W-1:0]    div_x_reg, div_x_next;
    logic [CAND_W-1:0]    div_src_reg, div_src_next;
    logic [ALIGN_W-1:0]   div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    // running peak and configuration
    logic [OFF_W-1:0]   peak_reg, peak_next;
    logic [ALIGN_W-1:0] alignment_reg, alignment_next;
    logic [CAP_W-1:0]   capacity_reg, capacity_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [OFF_W-1:0] out_offset_reg, out_offset_next;
    logic [OFF_W-1:0] out_peak_reg, out_peak_next;
    logic             out_over_reg, out_over_next;
    logic             out_full_reg, out_full_next;

    // datapath terms
    logic               scan_retire, scan_live, scan_above, scan_take, scan_end;
    logic [ALIGN_W-1:0] align_eff;
    logic [CAND_W:0]    step_sum;
    logic               step_fits;
    logic [CAND_W-1:0]  step_top;
    logic               step_raise;
    logic [ALIGN_W:0]   div_trial, div_diff;
    logic               div_ge;
    logic [ALIGN_W-1:0] adj_pad;
    logic [CAND_W-1:0]  adj_cand;
    logic [OFF_W-1:0]   cand_clamp;
    logic [CAND_W-1:0]  done_sum, done_max;
    logic [OFF_W-1:0]   done_peak;
    logic               done_go;

    // handshakes
    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid         = out_valid_reg;
    assign result.placed_offset = out_offset_reg;
    assign result.peak_bytes    = out_peak_reg;
    assign result.over_capacity = out_over_reg;
    assign result.table_full    = out_full_reg;

    // scan compare: retire, liveness, order key above last visit, new minimum
    assign rd_addr     = scan_cnt_reg[IDX_W-1:0];
    assign scan_retire = first_pass_reg && valid_reg[rd_idx_reg] && (rd_end_reg < start_reg);
    assign scan_live   = valid_reg[rd_idx_reg] && !scan_retire;
    assign scan_above  = first_pass_reg || (rd_off_reg > last_off_reg) ||
                         ((rd_off_reg == last_off_reg) && (rd_idx_reg > last_idx_reg));
    assign scan_take   = scan_live && scan_above &&
                         (!best_found_reg || (rd_off_reg < best_off_reg));
    assign scan_end    = (scan_cnt_reg == CNT_W'(MAX_ACTIVE)) && !rd_vld_reg;

    // zero alignment means no rounding
    assign align_eff = (alignment_reg == '0) ? ALIGN_W'(1) : alignment_reg;

    // gap test against the visited range
    assign step_sum   = {1'b0, cand_reg} + (CAND_W + 1)'(size_reg);
    assign step_fits  = step_sum <= (CAND_W + 1)'(best_off_reg);
    assign step_top   = CAND_W'(best_off_reg) + CAND_W'(best_size_reg);
    assign step_raise = step_top > cand_reg;

    // one remainder bit per cycle
    assign div_trial = {div_rem_reg, div_x_reg[CAND_W-1]};
    assign div_ge    = div_trial >= {1'b0, align_eff};
    assign div_diff  = div_trial - {1'b0, align_eff};

    // round up: add the distance to the next multiple
    assign adj_pad  = (div_rem_reg == '0) ? '0 : (align_eff - div_rem_reg);
    assign adj_cand = div_src_reg + CAND_W'(adj_pad);

    // final clamp and peak update
    assign cand_clamp = (cand_reg > CAND_W'(OFF_MAX)) ? OFF_MAX : cand_reg[OFF_W-1:0];
    assign done_sum   = CAND_W'(cand_clamp) + CAND_W'(size_reg);
    assign done_max   = (done_sum > CAND_W'(peak_reg)) ? done_sum : CAND_W'(peak_reg);
    assign done_peak  = (done_max > CAND_W'(OFF_MAX)) ? OFF_MAX : done_max[OFF_W-1:0];
    assign done_go    = !out_valid_reg || result.ready;

    assign mem_we = (state_reg == S_DONE) && done_go && free_found_reg;

    // sequencer and next-state logic
    always_comb
    begin
        state_next      = state_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        size_next       = size_reg;
        valid_next      = valid_reg;
        scan_cnt_next   = scan_cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        first_pass_next = first_pass_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_off_next   = best_off_reg;
        best_size_next  = best_size_reg;
        best_idx_next   = best_idx_reg;
        last_off_next   = last_off_reg;
        last_idx_next   = last_idx_reg;
        cand_next       = cand_reg;
        div_x_next      = div_x_reg;
        div_src_next    = div_src_reg;
        div_rem_next    = div_rem_reg;
        div_cnt_next    = div_cnt_reg;
        peak_next       = peak_reg;
        alignment_next  = alignment_reg;
        capacity_next   = capacity_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_offset_next = out_offset_reg;
        out_peak_next   = out_peak_reg;
        out_over_next   = out_over_reg;
        out_full_next   = out_full_reg;

        case (state_reg)
            // take a new word and start the retire pass
            S_IDLE:
            begin
                if (item.valid)
                begin
                    start_next      = item.lifetime_start;
                    end_next        = item.lifetime_end;
                    size_next       = item.block_size;
                    if (item.new_set)
                    begin
                        valid_next = '0;
                        peak_next  = '0;
                    end
                    cand_next       = '0;
                    first_pass_next = 1'b1;
                    free_found_next = 1'b0;
                    best_found_next = 1'b0;
                    scan_cnt_next   = '0;
                    state_next      = S_SCAN;
                end
            end

            // walk the table one slot a cycle
            S_SCAN:
            begin
                if (scan_cnt_reg != CNT_W'(MAX_ACTIVE))
                begin
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = rd_addr;
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (scan_retire)
                    begin
                        valid_next[rd_idx_reg] = 1'b0;
                    end
                    if (first_pass_reg && !scan_live && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                    if (scan_take)
                    begin
                        best_found_next = 1'b1;
                        best_off_next   = rd_off_reg;
                        best_size_next  = rd_size_reg;
                        best_idx_next   = rd_idx_reg;
                    end
                end
                if (scan_end)
                begin
                    first_pass_next = 1'b0;
                    if (first_pass_reg && !free_found_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else if (best_found_reg)
                    begin
                        state_next = S_STEP;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // first fit test against the lowest unvisited range
            S_STEP:
            begin
                if (step_fits)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    last_off_next   = best_off_reg;
                    last_idx_next   = best_idx_reg;
                    best_found_next = 1'b0;
                    scan_cnt_next   = '0;
                    if (step_raise)
                    begin
                        div_x_next   = step_top;
                        div_src_next = step_top;
                        div_rem_next = '0;
                        div_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            // remainder of the range top by the alignment
            S_DIV:
            begin
                div_rem_next = div_ge ? div_diff[ALIGN_W-1:0] : div_trial[ALIGN_W-1:0];
                div_x_next   = {div_x_reg[CAND_W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(CAND_W - 1))
                begin
                    state_next = S_ADJ;
                end
            end

            // aligned candidate, then look for the next range
            S_ADJ:
            begin
                cand_next  = adj_cand;
                state_next = S_SCAN;
            end

            // record the range if a slot was free and load the output register
            S_DONE:
            begin
                if (done_go)
                begin
                    out_valid_next = 1'b1;
                    if (free_found_reg)
                    begin
                        valid_next[free_idx_reg] = 1'b1;
                        peak_next       = done_peak;
                        out_offset_next = cand_clamp;
                        out_peak_next   = done_peak;
                        out_over_next   = CAND_W'(done_peak) > CAND_W'(capacity_reg);
                        out_full_next   = 1'b0;
                    end
                    else
                    begin
                        out_offset_next = '0;
                        out_peak_next   = peak_reg;
                        out_over_next   = CAND_W'(peak_reg) > CAND_W'(capacity_reg);
                        out_full_next   = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register writes
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_ALIGNMENT: alignment_next = cfg.data[ALIGN_W-1:0];
                REG_CAPACITY:  capacity_next  = cfg.data[CAP_W-1:0];
                default:       ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            peak_reg       <= '0;
            alignment_reg  <= ALIGN_RESET;
            capacity_reg   <= CAP_RESET;
            out_valid_reg  <= 1'b0;
            rd_vld_reg     <= 1'b0;
            scan_cnt_reg   <= '0;
            first_pass_reg <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            peak_reg       <= peak_next;
            alignment_reg  <= alignment_next;
            capacity_reg   <= capacity_next;
            out_valid_reg  <= out_valid_next;
            rd_vld_reg     <= rd_vld_next;
            scan_cnt_reg   <= scan_cnt_next;
            first_pass_reg <= first_pass_next;
            free_found_reg <= free_found_next;
            best_found_reg <= best_found_next;
            div_cnt_reg    <= div_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        end_reg        <= end_next;
        size_reg       <= size_next;
        rd_idx_reg     <= rd_idx_next;
        free_idx_reg   <= free_idx_next;
        best_off_reg   <= best_off_next;
        best_size_reg  <= best_size_next;
        best_idx_reg   <= best_idx_next;
        last_off_reg   <= last_off_next;
        last_idx_reg   <= last_idx_next;
        cand_reg       <= cand_next;
        div_x_reg      <= div_x_next;
        div_src_reg    <= div_src_next;
        div_rem_reg    <= div_rem_next;
        out_offset_reg <= out_offset_next;
        out_peak_reg   <= out_peak_next;
        out_over_reg   <= out_over_next;
        out_full_reg   <= out_full_next;
    end

    // range memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_end[free_idx_reg]  <= end_reg;
            mem_off[free_idx_reg]  <= cand_clamp;
            mem_size[free_idx_reg] <= size_reg;
        end
        rd_end_reg  <= mem_end[rd_addr];
        rd_off_reg  <= mem_off[rd_addr];
        rd_size_reg <= mem_size[rd_addr];
    end

    // checks
    `LFFOP_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready, !item.ready,
        "item accepted while a placement was still running")
    `LFFOP_ASSERT_NOW(a_full_offset_zero, result.valid && result.table_full,
        result.placed_offset == '0, "table full word carries a nonzero offset")
    `LFFOP_ASSERT_NOW(a_peak_covers_offset, result.valid && !result.table_full,
        result.peak_bytes >= result.placed_offset, "peak below placed offset")
    `LFFOP_ASSERT_NEXT(a_div_exit, state_reg == S_DIV,
        (state_reg == S_DIV) || (state_reg == S_ADJ), "remainder unit left early")

endmodule

[test/lifetime_first_fit_offset_planner_top_test.sv]
`timescale 1ns / 1ps

module lifetime_first_fit_offset_planner_top_test;
    import lffop_pkg::*;

    localparam int SLOTS = MAX_ACTIVE_DEF;
    localparam logic [POS_W-1:0]  POS_MAX  = {POS_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};
    localparam logic [CAP_W-1:0]  CAP_MAX  = {CAP_W{1'b1}};
    localparam int REPORT_LIMIT = 10;

    // one buffer lifetime as it enters the planner
    typedef struct {
        bit              new_set;
        bit [POS_W-1:0]  live_from;
        bit [POS_W-1:0]  live_to;
        bit [SIZE_W-1:0] bytes;
    } lifetime_t;

    // one placement word as it leaves the planner
    typedef struct {
        bit [OFF_W-1:0] placed;
        bit [OFF_W-1:0] peak;
        bit             over_cap;
        bit             full;
    } placement_t;

    logic clk;
    logic rst_n;

    lffop_item_if   item_ch ();
    lffop_result_if result_ch ();
    lffop_cfg_if    cfg_ch ();

    lifetime_first_fit_offset_planner_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // shadow of the planner state
    bit [POS_W-1:0]   shadow_end  [SLOTS];
    bit [OFF_W-1:0]   shadow_off  [SLOTS];
    bit [SIZE_W-1:0]  shadow_size [SLOTS];
    bit               shadow_live [SLOTS];
    bit [OFF_W-1:0]   shadow_peak;
    bit [ALIGN_W-1:0] shadow_align;
    bit [CAP_W-1:0]   shadow_cap;

    placement_t placement_q[$];

    bit jitter_on;
    int mismatches;
    int lifetimes_sent;
    int placements_seen;
    int full_seen;
    int over_seen;
    int settings_used;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #40_000_000;
        $display("lifetime_first_fit_offset_planner_top test failed");
        $finish;
    end

    function automatic longint unsigned align_up(longint unsigned x, longint unsigned grain);
        return ((x + grain - 1) / grain) * grain;
    endfunction

    // first-fit placement of one lifetime against the shadow table
    function automatic placement_t plan_placement(lifetime_t lt);
        bit seen [SLOTS];
        int free_idx;
        int pick;
        longint unsigned grain;
        longint unsigned cand;
        longint unsigned top;
        longint unsigned peak;
        placement_t res;
        free_idx = -1;
        cand = 0;
        grain = (shadow_align == 0) ? 1 : shadow_align;
        if (lt.new_set)
        begin
            foreach (shadow_live[i])
                shadow_live[i] = 1'b0;
            shadow_peak = '0;
        end
        // retire ranges that ended before this start, find the first free slot
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_live[i] && shadow_end[i] < lt.live_from)
                shadow_live[i] = 1'b0;
            if (!shadow_live[i] && free_idx < 0)
                free_idx = i;
        end
        if (free_idx < 0)
        begin
            res.placed = '0;
            res.peak = shadow_peak;
            res.over_cap = shadow_peak > shadow_cap;
            res.full = 1'b1;
            return res;
        end
        // walk live ranges by offset, slot order on ties
        foreach (seen[i])
            seen[i] = 1'b0;
        forever
        begin
            pick = -1;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (shadow_live[i] && !seen[i] &&
                    (pick < 0 || shadow_off[i] < shadow_off[pick]))
                    pick = i;
            end
            if (pick < 0)
                break;
            seen[pick] = 1'b1;
            cand = align_up(cand, grain);
            if (cand + lt.bytes <= shadow_off[pick])
                break;
            top = longint'(shadow_off[pick]) + shadow_size[pick];
            if (top > cand)
                cand = top;
        end
        cand = align_up(cand, grain);
        if (cand > OFF_MAX)
            cand = OFF_MAX;
        peak = cand + lt.bytes;
        if (peak < shadow_peak)
            peak = shadow_peak;
        if (peak > OFF_MAX)
            peak = OFF_MAX;
        shadow_peak = peak[OFF_W-1:0];
        shadow_end[free_idx] = lt.live_to;
        shadow_off[free_idx] = cand[OFF_W-1:0];
        shadow_size[free_idx] = lt.bytes;
        shadow_live[free_idx] = 1'b1;
        res.placed = cand[OFF_W-1:0];
        res.peak = peak[OFF_W-1:0];
        res.over_cap = peak > shadow_cap;
        res.full = 1'b0;
        return res;
    endfunction

    // send one lifetime word and record its expected placement
    task automatic send_lifetime(lifetime_t lt);
        while (jitter_on && $urandom_range(99) < 30)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.new_set <= lt.new_set;
        item_ch.lifetime_start <= lt.live_from;
        item_ch.lifetime_end <= lt.live_to;
        item_ch.block_size <= lt.bytes;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        placement_q.insert(placement_q.size(), plan_placement(lt));
        lifetimes_sent++;
    endtask

    task automatic send_fields(bit ns, bit [POS_W-1:0] from_pos, bit [POS_W-1:0] to_pos,
                               bit [SIZE_W-1:0] bytes);
        lifetime_t lt;
        lt.new_set = ns;
        lt.live_from = from_pos;
        lt.live_to = to_pos;
        lt.bytes = bytes;
        send_lifetime(lt);
    endtask

    // stop sending and let every outstanding placement come back
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // write both registers back to back while the planner is idle
    task automatic set_registers(bit [ALIGN_W-1:0] align, bit [CAP_W-1:0] cap);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= REG_ALIGNMENT;
        cfg_ch.data <= CFG_DATA_W'(align);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        shadow_align = align;
        cfg_ch.index <= REG_CAPACITY;
        cfg_ch.data <= cap;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        shadow_cap = cap;
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    // result side: random stalls and comparison against the oldest expectation
    always @(posedge clk)
    begin
        placement_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (placement_q.size() == 0)
                report_mismatch("unexpected word, offset", 0, result_ch.placed_offset);
            else
            begin
                want = placement_q.pop_front();
                placements_seen++;
                if (result_ch.table_full)
                    full_seen++;
                if (result_ch.over_capacity)
                    over_seen++;
                if (result_ch.placed_offset !== want.placed)
                    report_mismatch("placed_offset", want.placed, result_ch.placed_offset);
                if (result_ch.peak_bytes !== want.peak)
                    report_mismatch("peak_bytes", want.peak, result_ch.peak_bytes);
                if (result_ch.over_capacity !== want.over_cap)
                    report_mismatch("over_capacity", want.over_cap, result_ch.over_capacity);
                if (result_ch.table_full !== want.full)
                    report_mismatch("table_full", want.full, result_ch.table_full);
            end
        end
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= !(jitter_on && $urandom_range(99) < 30);
    end

    // default registers, field extremes, capacity exceeded at once
    task automatic test_reset_defaults();
        send_fields(1'b1, '0, POS_MAX, 24'd1);
        send_fields(1'b0, 20'd5, 20'd10, SIZE_MAX);
        send_fields(1'b0, POS_MAX, POS_MAX, 24'd100);
        wait_idle();
    endtask

    // zero alignment, minimum capacity, zero sizes sharing an offset, inverted lifetime
    task automatic test_odd_alignment();
        set_registers('0, 26'd1);
        send_fields(1'b1, '0, '0, '0);
        send_fields(1'b0, '0, '0, '0);
        send_fields(1'b0, 20'd10, 20'd3, 24'd7);
        send_fields(1'b0, 20'd11, 20'd20, 24'd3);
        send_fields(1'b0, 20'd4, 20'd30, 24'd5);
        wait_idle();
    endtask

    // alignment of 4096 and a non-power-of-two one
    task automatic test_wide_alignment();
        set_registers(13'd4096, CAP_MAX);
        send_fields(1'b1, 20'd100, 20'd200, 24'd1);
        send_fields(1'b0, 20'd100, 20'd200, 24'd1);
        wait_idle();
        set_registers(13'd4095, CAP_MAX);
        send_fields(1'b1, 20'd7, 20'd9, 24'd4096);
        send_fields(1'b0, 20'd8, 20'd9, 24'd2);
        wait_idle();
    endtask

    // stack maximum-size buffers until offsets clamp and every slot is taken
    task automatic test_table_full_overflow();
        set_registers(13'd1, CAP_MAX);
        for (int n = 0; n <= SLOTS; n++)
            send_fields(n == 0, 20'd50, POS_MAX, SIZE_MAX);
        wait_idle();
    endtask

    // random register settings with mostly ordered lifetime sets
    task automatic test_random_sets(int phases, int per_phase);
        int left;
        int reach;
        longint unsigned pos;
        longint unsigned stop_pos;
        bit [ALIGN_W-1:0] align;
        bit [CAP_W-1:0] cap;
        lifetime_t lt;
        for (int p = 0; p < phases; p++)
        begin
            case (p)
                0: begin align = 13'd1;    cap = CAP_MAX; end
                1: begin align = 13'd4096; cap = 26'd1;   end
                default:
                begin
                    align = $urandom_range(1) ? 13'(1 << $urandom_range(12))
                                              : 13'($urandom_range(1, 4096));
                    cap = $urandom_range(1) ? 26'($urandom_range(1, 1 << 20))
                                            : 26'($urandom_range(1, CAP_MAX));
                end
            endcase
            // one phase runs with both sides streaming
            jitter_on = (p != 2);
            set_registers(align, cap);
            left = 0;
            reach = 3;
            pos = 0;
            for (int n = 0; n < per_phase; n++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    lt.new_set = 1'($urandom_range(1));
                    lt.live_from = POS_W'($urandom_range(0, POS_MAX));
                    lt.live_to = POS_W'($urandom_range(0, POS_MAX));
                    lt.bytes = SIZE_W'($urandom_range(0, SIZE_MAX));
                end
                else
                begin
                    lt.new_set = (left == 0);
                    if (left == 0)
                    begin
                        left = $urandom_range(1, 40);
                        pos = ($urandom_range(9) == 0) ? 64'($urandom_range(0, POS_MAX))
                                                       : 64'($urandom_range(0, 1000));
                        case ($urandom_range(2))
                            0: reach = 3;
                            1: reach = 40;
                            default: reach = 600;
                        endcase
                    end
                    left--;
                    pos = pos + $urandom_range(0, 4);
                    if (pos > POS_MAX)
                        pos = POS_MAX;
                    stop_pos = pos + $urandom_range(0, reach);
                    if (stop_pos > POS_MAX)
                        stop_pos = POS_MAX;
                    lt.live_from = pos[POS_W-1:0];
                    lt.live_to = stop_pos[POS_W-1:0];
                    case ($urandom_range(99)) inside
                        [0:2]:   lt.bytes = '0;
                        [3:12]:  lt.bytes = SIZE_W'($urandom_range(1, SIZE_MAX));
                        default: lt.bytes = SIZE_W'($urandom_range(1, 5000));
                    endcase
                end
                send_lifetime(lt);
            end
            wait_idle();
        end
        jitter_on = 1'b1;
    endtask

    // stimulus sequence
    initial
    begin
        rst_n = 1'b0;
        jitter_on = 1'b1;
        mismatches = 0;
        lifetimes_sent = 0;
        placements_seen = 0;
        full_seen = 0;
        over_seen = 0;
        settings_used = 0;
        item_ch.valid <= 1'b0;
        item_ch.new_set <= 1'b0;
        item_ch.lifetime_start <= '0;
        item_ch.lifetime_end <= '0;
        item_ch.block_size <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_ALIGNMENT;
        cfg_ch.data <= '0;
        shadow_align = ALIGN_RESET;
        shadow_cap = CAP_RESET;
        shadow_peak = '0;
        foreach (shadow_live[i])
            shadow_live[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_odd_alignment();
        test_wide_alignment();
        test_table_full_overflow();
        test_random_sets(8, 128);

        // catch stray words after the last expected one
        repeat (1000) @(posedge clk);
        if (placement_q.size() != 0)
            report_mismatch("words never returned", 0, placement_q.size());
        $display("sent %0d lifetimes under %0d register settings, checked %0d placements",
                 lifetimes_sent, settings_used, placements_seen);
        $display("%0d table-full and %0d over-capacity words seen, %0d mismatches",
                 full_seen, over_seen, mismatches);
        if (mismatches == 0)
            $display("lifetime_first_fit_offset_planner_top test passed");
        else
            $display("lifetime_first_fit_offset_planner_top test failed");
        $finish;
    end

endmodule
